// ===== hw/rtl/pll_divider_search_defines.svh =====
// ----------------------------------------------------------------------------
// pll_divider_search_defines.svh
// assertion macros shared by the divider search rtl; empty for synthesis
// ----------------------------------------------------------------------------
`ifndef PLL_DIVIDER_SEARCH_DEFINES_SVH
`define PLL_DIVIDER_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define PDS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PDS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PDS_ASSERT_IMP(label, ante, cons, msg)
`define PDS_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/pds_pkg.sv =====
// ----------------------------------------------------------------------------
// pds_pkg
// types, constants and the known-clock rom of the pll divider search
// ----------------------------------------------------------------------------
package pds_pkg;

  // field widths
  localparam int TGT_W  = 20;
  localparam int REF_W  = 18;
  localparam int RDIV_W = 3;
  localparam int MULT_W = 8;
  localparam int ODIV_W = 7;
  localparam int ERR_W  = 10;
  localparam int Q_W    = 17;  // reference clock over reference divider
  localparam int DVD_W  = 24;  // serial divider dividend and quotient
  localparam int DSR_W  = 7;   // serial divider divisor

  // search ranges and limits
  localparam logic [REF_W-1:0]  REF_RESET   = 18'd100000;
  localparam logic [ERR_W-1:0]  TOL_KHZ     = 10'd1000;
  localparam logic [RDIV_W-1:0] RDIV_FIRST  = 3'd3;
  localparam logic [RDIV_W-1:0] RDIV_LAST   = 3'd5;
  localparam logic [ODIV_W-1:0] ODIV_FIRST  = 7'd6;
  localparam logic [ODIV_W-1:0] ODIV_LAST   = 7'd63;
  localparam logic [MULT_W-1:0] MULT_CAP    = 8'd160;
  localparam int                MULT_LO_FAC = 12;
  localparam int                MULT_HI_FAC = 32;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_QSTART,
    S_QWAIT,
    S_MUL,
    S_FSTART,
    S_FWAIT
  } fsm_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_TABLE  = 2'd0,
    ST_SEARCH = 2'd1,
    ST_NONE   = 2'd2
  } status_e;

  // serial divider request and response
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // known clock rom
  typedef struct packed {
    logic [TGT_W-1:0]  khz;
    logic [RDIV_W-1:0] rdiv;
    logic [MULT_W-1:0] mult;
    logic [ODIV_W-1:0] odiv;
  } rom_entry_t;

  localparam int ROM_DEPTH = 28;
  localparam int ROM_IDX_W = $clog2(ROM_DEPTH);

  localparam rom_entry_t CLOCK_ROM [ROM_DEPTH] = '{
    '{20'd148500, 3'd3, 8'd49,  7'd11},
    '{20'd174500, 3'd3, 8'd89,  7'd17},
    '{20'd181250, 3'd4, 8'd58,  7'd8},
    '{20'd297000, 3'd4, 8'd95,  7'd8},
    '{20'd301992, 3'd5, 8'd151, 7'd10},
    '{20'd146250, 3'd5, 8'd117, 7'd16},
    '{20'd135000, 3'd4, 8'd54,  7'd10},
    '{20'd119000, 3'd5, 8'd119, 7'd20},
    '{20'd108000, 3'd5, 8'd81,  7'd15},
    '{20'd106500, 3'd4, 8'd81,  7'd19},
    '{20'd88750,  3'd5, 8'd71,  7'd16},
    '{20'd83500,  3'd5, 8'd71,  7'd17},
    '{20'd71000,  3'd5, 8'd71,  7'd20},
    '{20'd74250,  3'd3, 8'd49,  7'd22},
    '{20'd78750,  3'd5, 8'd63,  7'd16},
    '{20'd75000,  3'd4, 8'd87,  7'd29},
    '{20'd65000,  3'd3, 8'd39,  7'd20},
    '{20'd51200,  3'd5, 8'd64,  7'd25},
    '{20'd57284,  3'd4, 8'd55,  7'd24},
    '{20'd49500,  3'd5, 8'd99,  7'd40},
    '{20'd50000,  3'd4, 8'd88,  7'd44},
    '{20'd40000,  3'd3, 8'd36,  7'd30},
    '{20'd36000,  3'd4, 8'd72,  7'd50},
    '{20'd31500,  3'd5, 8'd63,  7'd40},
    '{20'd30240,  3'd4, 8'd75,  7'd62},
    '{20'd27000,  3'd4, 8'd54,  7'd50},
    '{20'd25175,  3'd5, 8'd107, 7'd85},
    '{20'd25200,  3'd5, 8'd63,  7'd50}
  };

  // lowest multiplier allowed for a reference divider
  function automatic logic [MULT_W-1:0] mult_lo(input logic [RDIV_W-1:0] rdiv);
    int prod;
    prod = MULT_LO_FAC * int'(rdiv);
    return MULT_W'(prod);
  endfunction

  // highest multiplier allowed for a reference divider, capped at 160
  function automatic logic [MULT_W-1:0] mult_hi(input logic [RDIV_W-1:0] rdiv);
    int prod;
    prod = MULT_HI_FAC * int'(rdiv);
    if (prod > int'(MULT_CAP)) begin
      prod = int'(MULT_CAP);
    end
    return MULT_W'(prod);
  endfunction

endpackage

// ===== hw/rtl/pds_serdiv.sv =====
// ----------------------------------------------------------------------------
// pds_serdiv
// restoring bit-serial divider, one quotient bit per clock
// ----------------------------------------------------------------------------
`include "pll_divider_search_defines.svh"

module pds_serdiv import pds_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   trial_sub;
  logic             take;

  // trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    trial     = {rem_q, dvd_q[DVD_W-1]};
    take      = (trial >= {1'b0, dsr_q});
    trial_sub = trial - {1'b0, dsr_q};
  end

  // load on start, then shift one dividend bit in and one quotient bit out
  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d = req_i.dividend;
      dsr_d = req_i.divisor;
      rem_d = '0;
      cnt_d = CNT_W'(DVD_W);
    end else if (cnt_q != '0) begin
      dvd_d  = {dvd_q[DVD_W-2:0], take};
      rem_d  = take ? trial_sub[DSR_W-1:0] : trial[DSR_W-1:0];
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // data shift registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

  // checks
  `PDS_ASSERT_IMP(a_start_idle, req_i.start, cnt_q == '0, "divider started while running")
  `PDS_ASSERT_NXT(a_start_runs, req_i.start, cnt_q != '0, "divider did not start")
  `PDS_ASSERT_IMP(a_rem_bound, done_q, rem_q < dsr_q, "remainder not below divisor")
  `PDS_ASSERT_NXT(a_done_pulse, done_q, !done_q, "divider done longer than one cycle")

endmodule

// ===== hw/rtl/pll_divider_search.sv =====
// ----------------------------------------------------------------------------
// pll_divider_search
// pixel clock request to pll reference divider, multiplier and output divider
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; busy_o stays high
// until the answer is out, and the answer appears for exactly one cycle with
// done_o high, so the receiver has to capture it then. The known-clock rom is
// checked first at one entry per cycle (up to 28 entries). Without a table hit
// the search runs on one bit-serial divider that yields one quotient bit per
// cycle: each reference-divider step forms ref/div_ref, and each multiplier
// candidate forms the product, then does a 24-bit division by the output
// divider. The full search covers 14094 candidates; an exact hit ends it
// early. The reference clock register is written through the cfg channel;
// the user must write it only between requests; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "pll_divider_search_defines.svh"

module pll_divider_search import pds_pkg::*; #(
  parameter int TABLE_ENTRIES = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request
  input  logic        start_i,
  output logic        busy_o,
  input  logic [19:0] target_khz_i,
  // result
  output logic        done_o,
  output logic [2:0]  ref_divider_o,
  output logic [8:0]  loop_multiplier_o,
  output logic [6:0]  out_divider_o,
  output logic [1:0]  status_o,
  output logic [9:0]  error_khz_o,
  // reference clock register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [17:0] cfg_data_i
);

  localparam int SCAN_LEN = (TABLE_ENTRIES > ROM_DEPTH) ? ROM_DEPTH : TABLE_ENTRIES;

  fsm_e state_q, state_d;

  logic [REF_W-1:0]     ref_q;
  logic [TGT_W-1:0]     target_q, target_d;
  logic [ROM_IDX_W-1:0] idx_q, idx_d;
  logic [RDIV_W-1:0]    rdiv_q, rdiv_d;
  logic [MULT_W-1:0]    mult_q, mult_d;
  logic [ODIV_W-1:0]    odiv_q, odiv_d;
  logic [Q_W-1:0]       quo_q, quo_d;
  logic [DVD_W-1:0]     prod_q, prod_d;
  logic [ERR_W-1:0]     best_q, best_d;
  logic [RDIV_W-1:0]    brdiv_q, brdiv_d;
  logic [MULT_W-1:0]    bmult_q, bmult_d;
  logic [ODIV_W-1:0]    bodiv_q, bodiv_d;
  logic                 found_q, found_d;
  logic                 done_q, done_d;
  logic [RDIV_W-1:0]    res_rdiv_q, res_rdiv_d;
  logic [MULT_W-1:0]    res_mult_q, res_mult_d;
  logic [ODIV_W-1:0]    res_odiv_q, res_odiv_d;
  status_e              res_status_q, res_status_d;
  logic [ERR_W-1:0]     res_err_q, res_err_d;

  div_req_t   div_req;
  div_rsp_t   div_rsp;
  rom_entry_t rom_ent;

  logic             accept;
  logic             rom_hit;
  logic             scan_last;
  logic             last_mult;
  logic             last_rdiv;
  logic             last_odiv;
  logic [DVD_W-1:0] tgt_ext;
  logic [DVD_W-1:0] freq;
  logic [DVD_W-1:0] diff;
  logic             improve;
  logic             exact;
  logic [ERR_W-1:0] sel_best;
  logic [RDIV_W-1:0] sel_rdiv;
  logic [MULT_W-1:0] sel_mult;
  logic [ODIV_W-1:0] sel_odiv;
  logic             sel_found;

  // shared serial divider
  pds_serdiv u_serdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign accept      = start_i && (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // table lookup and loop bounds
  always_comb begin
    rom_ent   = CLOCK_ROM[idx_q];
    rom_hit   = (rom_ent.khz == target_q);
    scan_last = (idx_q == ROM_IDX_W'(SCAN_LEN - 1));
    last_mult = (mult_q == mult_hi(rdiv_q));
    last_rdiv = (rdiv_q == RDIV_LAST);
    last_odiv = (odiv_q == ODIV_LAST);
  end

  // candidate error against the best so far
  always_comb begin
    tgt_ext   = DVD_W'(target_q);
    freq      = div_rsp.quotient;
    diff      = (tgt_ext >= freq) ? (tgt_ext - freq) : (freq - tgt_ext);
    improve   = (diff < DVD_W'(best_q));
    exact     = improve && (diff == '0);
    sel_best  = improve ? diff[ERR_W-1:0] : best_q;
    sel_rdiv  = improve ? rdiv_q : brdiv_q;
    sel_mult  = improve ? mult_q : bmult_q;
    sel_odiv  = improve ? odiv_q : bodiv_q;
    sel_found = improve || found_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (rom_hit) begin
          state_d = S_IDLE;
        end else if (scan_last) begin
          state_d = S_QSTART;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_QSTART: state_d = S_QWAIT;
      S_QWAIT: begin
        if (div_rsp.done) begin
          state_d = S_MUL;
        end
      end
      S_MUL:    state_d = S_FSTART;
      S_FSTART: state_d = S_FWAIT;
      S_FWAIT: begin
        if (div_rsp.done) begin
          priority if (exact) begin
            state_d = S_IDLE;
          end else if (last_mult && last_rdiv && last_odiv) begin
            state_d = S_IDLE;
          end else if (last_mult) begin
            state_d = S_QSTART;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    target_d     = target_q;
    idx_d        = idx_q;
    rdiv_d       = rdiv_q;
    mult_d       = mult_q;
    odiv_d       = odiv_q;
    quo_d        = quo_q;
    prod_d       = prod_q;
    best_d       = best_q;
    brdiv_d      = brdiv_q;
    bmult_d      = bmult_q;
    bodiv_d      = bodiv_q;
    found_d      = found_q;
    done_d       = 1'b0;
    res_rdiv_d   = res_rdiv_q;
    res_mult_d   = res_mult_q;
    res_odiv_d   = res_odiv_q;
    res_status_d = res_status_q;
    res_err_d    = res_err_q;
    div_req      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          target_d = target_khz_i;
          idx_d    = '0;
        end
      end
      S_SCAN: begin
        priority if (rom_hit) begin
          done_d       = 1'b1;
          res_rdiv_d   = rom_ent.rdiv;
          res_mult_d   = rom_ent.mult;
          res_odiv_d   = rom_ent.odiv;
          res_status_d = ST_TABLE;
          res_err_d    = '0;
        end else if (scan_last) begin
          odiv_d  = ODIV_FIRST;
          rdiv_d  = RDIV_FIRST;
          mult_d  = mult_lo(RDIV_FIRST);
          best_d  = TOL_KHZ;
          found_d = 1'b0;
        end else begin
          idx_d = idx_q + ROM_IDX_W'(1);
        end
      end
      // reference clock over reference divider
      S_QSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(ref_q);
        div_req.divisor  = DSR_W'(rdiv_q);
      end
      S_QWAIT: begin
        if (div_rsp.done) begin
          quo_d = div_rsp.quotient[Q_W-1:0];
        end
      end
      // full-width product, always below 2^24
      S_MUL: begin
        prod_d = DVD_W'(quo_q) * DVD_W'(mult_q);
      end
      // product over output divider
      S_FSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = DSR_W'(odiv_q);
      end
      S_FWAIT: begin
        if (div_rsp.done) begin
          best_d  = sel_best;
          brdiv_d = sel_rdiv;
          bmult_d = sel_mult;
          bodiv_d = sel_odiv;
          found_d = sel_found;
          priority if (exact) begin
            done_d       = 1'b1;
            res_rdiv_d   = rdiv_q;
            res_mult_d   = mult_q;
            res_odiv_d   = odiv_q;
            res_status_d = ST_SEARCH;
            res_err_d    = '0;
          end else if (last_mult && last_rdiv && last_odiv) begin
            done_d = 1'b1;
            if (sel_found) begin
              res_rdiv_d   = sel_rdiv;
              res_mult_d   = sel_mult;
              res_odiv_d   = sel_odiv;
              res_status_d = ST_SEARCH;
              res_err_d    = sel_best;
            end else begin
              res_rdiv_d   = '0;
              res_mult_d   = '0;
              res_odiv_d   = '0;
              res_status_d = ST_NONE;
              res_err_d    = TOL_KHZ;
            end
          end else if (last_mult && last_rdiv) begin
            odiv_d = odiv_q + ODIV_W'(1);
            rdiv_d = RDIV_FIRST;
            mult_d = mult_lo(RDIV_FIRST);
          end else if (last_mult) begin
            rdiv_d = rdiv_q + RDIV_W'(1);
            mult_d = mult_lo(rdiv_q + RDIV_W'(1));
          end else begin
            mult_d = mult_q + MULT_W'(1);
          end
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      ref_q   <= REF_RESET;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ref_q <= cfg_data_i;
      end
    end
  end

  // search and result registers
  always_ff @(posedge clk_i) begin
    target_q     <= target_d;
    idx_q        <= idx_d;
    rdiv_q       <= rdiv_d;
    mult_q       <= mult_d;
    odiv_q       <= odiv_d;
    quo_q        <= quo_d;
    prod_q       <= prod_d;
    best_q       <= best_d;
    brdiv_q      <= brdiv_d;
    bmult_q      <= bmult_d;
    bodiv_q      <= bodiv_d;
    found_q      <= found_d;
    res_rdiv_q   <= res_rdiv_d;
    res_mult_q   <= res_mult_d;
    res_odiv_q   <= res_odiv_d;
    res_status_q <= res_status_d;
    res_err_q    <= res_err_d;
  end

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign ref_divider_o     = res_rdiv_q;
  assign loop_multiplier_o = {1'b0, res_mult_q};
  assign out_divider_o     = res_odiv_q;
  assign status_o          = res_status_q;
  assign error_khz_o       = res_err_q;

  // checks
  `PDS_ASSERT_IMP(a_done_idle, done_o, !busy_o, "result shown while busy")
  `PDS_ASSERT_NXT(a_accept_busy, start_i && !busy_o, busy_o, "request taken but not busy")
  `PDS_ASSERT_IMP(a_none_zero, done_o && status_o == ST_NONE, error_khz_o == TOL_KHZ && ref_divider_o == '0 && loop_multiplier_o == '0 && out_divider_o == '0, "not found result not cleared")
  `PDS_ASSERT_IMP(a_search_tol, done_o && status_o == ST_SEARCH, error_khz_o < TOL_KHZ && ref_divider_o >= RDIV_FIRST && ref_divider_o <= RDIV_LAST, "search result out of range")
  `PDS_ASSERT_IMP(a_table_exact, done_o && status_o == ST_TABLE, error_khz_o == '0, "table hit with error")

endmodule
